### hdl/cfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared constants, types and the CRC-32 byte update for the frame receiver.
// ----------------------------------------------------------------------------
package cfr_pkg;

    localparam int MAX_PAYLOAD = 16;
    localparam int HEADER_LEN  = 4;
    localparam int CRC_LEN     = 4;
    localparam int FIELD_BYTES = 16;
    localparam int FB_W        = $clog2(FIELD_BYTES);
    localparam int POS_W       = $clog2(MAX_PAYLOAD + HEADER_LEN + CRC_LEN + 1);
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int OUT_LEN_W   = 5;

    localparam logic [7:0]  START_BYTE = 8'hFA;
    localparam logic [7:0]  REG_RESET  = 8'hE0;
    localparam logic [31:0] CRC_POLY   = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Class of a byte as decided by the front end.
    typedef enum logic [1:0] {
        K_START,
        K_HDR,
        K_PAY,
        K_CRC
    } t_kind;

    // Front end parser phase.
    typedef enum logic [2:0] {
        S_HUNT,
        S_REG,
        S_LEN_LO,
        S_LEN_HI,
        S_PAYLOAD,
        S_CRC
    } t_fstate;

    typedef struct packed {
        t_kind             kind;
        logic [7:0]        data;
        logic [POS_W-1:0]  idx;
        logic              last;
        logic [LEN_W-1:0]  len;
    } t_cmd;

    typedef struct packed {
        logic                 frame_status;
        logic [OUT_LEN_W-1:0] payload_length;
        logic [15:0]          distance_mm;
        logic [15:0]          temperature_centi;
        logic [15:0]          amplitude;
        logic [15:0]          ambient_light;
        logic [63:0]          tof_phase;
    } t_result;

    // MSB-first CRC-32 update over one byte.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {b, 24'h0};
        for (int k = 0; k < 8; k++) begin
            c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

### hdl/cfr_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfr_ifs
// Valid/ready channel interfaces for received bytes, configuration and results.
// ----------------------------------------------------------------------------
interface cfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfr_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cfr_result_if;
    logic        valid;
    logic        ready;
    logic        frame_status;
    logic [4:0]  payload_length;
    logic [15:0] distance_mm;
    logic [15:0] temperature_centi;
    logic [15:0] amplitude;
    logic [15:0] ambient_light;
    logic [63:0] tof_phase;
    modport source (output valid, output frame_status, output payload_length,
                    output distance_mm, output temperature_centi, output amplitude,
                    output ambient_light, output tof_phase, input ready);
    modport sink   (input valid, input frame_status, input payload_length,
                    input distance_mm, input temperature_centi, input amplitude,
                    input ambient_light, input tof_phase, output ready);
endinterface
`default_nettype wire

### hdl/cfr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfr_front
// Frame parser: accepts bytes, tracks the frame layout and classifies each byte.
// ----------------------------------------------------------------------------
module cfr_front
    import cfr_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    cfr_byte_if.sink    i_rx,
    cfr_cfg_if.sink     i_cfg,
    input  wire         i_q_ready,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd
);

    t_fstate          r_state, n_state;
    logic [POS_W-1:0] r_idx, n_idx;
    logic [LEN_W-1:0] r_len, n_len;
    logic [7:0]       r_len_lo, n_len_lo;
    logic [7:0]       r_exp_reg;
    logic             accept;
    logic [15:0]      len16;

    assign i_rx.ready  = i_q_ready;
    assign i_cfg.ready = 1'b1;
    assign accept      = i_rx.valid & i_q_ready;
    assign len16       = {i_rx.rx_byte, r_len_lo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_HUNT;
            r_idx     <= '0;
            r_len     <= '0;
            r_len_lo  <= '0;
            r_exp_reg <= REG_RESET;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_len    <= n_len;
            r_len_lo <= n_len_lo;
            if (i_cfg.valid) begin
                r_exp_reg <= i_cfg.data;
            end
        end
    end

    // Next state.
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_len    = r_len;
        n_len_lo = r_len_lo;
        if (accept) begin
            case (r_state)
                S_HUNT: begin
                    if (i_rx.rx_byte == START_BYTE) begin
                        n_state = S_REG;
                    end
                end
                S_REG: begin
                    n_state = (i_rx.rx_byte == r_exp_reg) ? S_LEN_LO : S_HUNT;
                end
                S_LEN_LO: begin
                    n_len_lo = i_rx.rx_byte;
                    n_state  = S_LEN_HI;
                end
                S_LEN_HI: begin
                    n_idx = '0;
                    n_len = LEN_W'(len16);
                    if (len16 > 16'(MAX_PAYLOAD)) begin
                        n_state = S_HUNT;
                    end else if (len16 == 16'd0) begin
                        n_state = S_CRC;
                    end else begin
                        n_state = S_PAYLOAD;
                    end
                end
                S_PAYLOAD: begin
                    if (r_idx == POS_W'(r_len) - POS_W'(1)) begin
                        n_idx   = '0;
                        n_state = S_CRC;
                    end else begin
                        n_idx = r_idx + POS_W'(1);
                    end
                end
                S_CRC: begin
                    if (r_idx == POS_W'(CRC_LEN - 1)) begin
                        n_idx   = '0;
                        n_state = S_HUNT;
                    end else begin
                        n_idx = r_idx + POS_W'(1);
                    end
                end
                default: begin
                    n_state = S_HUNT;
                end
            endcase
        end
    end

    // Outputs towards the queue.
    always_comb begin
        o_cmd.data  = i_rx.rx_byte;
        o_cmd.idx   = r_idx;
        o_cmd.len   = r_len;
        o_cmd.last  = 1'b0;
        o_cmd.kind  = K_HDR;
        o_cmd_valid = accept;
        case (r_state)
            S_HUNT: begin
                o_cmd.kind  = K_START;
                o_cmd_valid = accept & (i_rx.rx_byte == START_BYTE);
            end
            S_REG: begin
                o_cmd_valid = accept & (i_rx.rx_byte == r_exp_reg);
            end
            S_LEN_LO, S_LEN_HI: begin
                o_cmd.kind = K_HDR;
            end
            S_PAYLOAD: begin
                o_cmd.kind = K_PAY;
            end
            S_CRC: begin
                o_cmd.kind = K_CRC;
                o_cmd.last = (r_idx == POS_W'(CRC_LEN - 1));
            end
            default: begin
                o_cmd_valid = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

### hdl/cfr_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfr_queue
// Short FIFO of classified bytes between the parser and the checker.
// ----------------------------------------------------------------------------
module cfr_queue
    import cfr_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_push,
    input  t_cmd  i_cmd,
    output logic  o_ready,
    input  wire   i_pop,
    output logic  o_valid,
    output t_cmd  o_cmd
);

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, r_rd;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               do_push, do_pop;

    assign o_ready = (r_cnt != Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push & o_ready;
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + Q_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + Q_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - Q_CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

### hdl/cfr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfr_back
// Checker: runs the CRC, captures payload and received CRC, emits the result.
// ----------------------------------------------------------------------------
module cfr_back
    import cfr_pkg::*;
(
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_cmd_valid,
    input  t_cmd           i_cmd,
    output logic           o_pop,
    cfr_result_if.source   o_res
);

    logic [31:0] r_crc;
    logic [31:0] r_rx_crc;
    logic [7:0]  r_pay [FIELD_BYTES];
    logic        r_out_valid;
    t_result     r_res;
    logic [31:0] crc_next;
    logic [31:0] rx_full;
    logic [7:0]  pay_masked [FIELD_BYTES];

    assign o_pop    = i_cmd_valid & (~i_cmd.last | ~r_out_valid | o_res.ready);
    assign crc_next = crc32_byte((i_cmd.kind == K_START) ? CRC_INIT : r_crc, i_cmd.data);
    assign rx_full  = {i_cmd.data, r_rx_crc[31:8]};

    // Payload bytes at or beyond the frame length read as zero.
    always_comb begin
        for (int p = 0; p < FIELD_BYTES; p++) begin
            pay_masked[p] = (LEN_W'(p) < i_cmd.len) ? r_pay[p] : 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= CRC_INIT;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && (i_cmd.kind != K_CRC)) begin
                r_crc <= crc_next;
            end
            if (o_pop && i_cmd.last) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && (i_cmd.kind == K_PAY) && (i_cmd.idx < POS_W'(FIELD_BYTES))) begin
            r_pay[i_cmd.idx[FB_W-1:0]] <= i_cmd.data;
        end
        if (o_pop && (i_cmd.kind == K_CRC)) begin
            r_rx_crc <= rx_full;
        end
        if (o_pop && i_cmd.last) begin
            r_res.frame_status      <= (rx_full != r_crc);
            r_res.payload_length    <= OUT_LEN_W'(i_cmd.len);
            r_res.distance_mm       <= {pay_masked[1], pay_masked[0]};
            r_res.temperature_centi <= {pay_masked[3], pay_masked[2]};
            r_res.amplitude         <= {pay_masked[5], pay_masked[4]};
            r_res.ambient_light     <= {pay_masked[7], pay_masked[6]};
            r_res.tof_phase         <= {pay_masked[15], pay_masked[14], pay_masked[13],
                                        pay_masked[12], pay_masked[11], pay_masked[10],
                                        pay_masked[9], pay_masked[8]};
        end
    end

    assign o_res.valid             = r_out_valid;
    assign o_res.frame_status      = r_res.frame_status;
    assign o_res.payload_length    = r_res.payload_length;
    assign o_res.distance_mm       = r_res.distance_mm;
    assign o_res.temperature_centi = r_res.temperature_centi;
    assign o_res.amplitude         = r_res.amplitude;
    assign o_res.ambient_light     = r_res.ambient_light;
    assign o_res.tof_phase         = r_res.tof_phase;

endmodule
`default_nettype wire

### hdl/crc32_frame_receiver_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crc32_frame_receiver_top
// Length-prefixed serial frame receiver with CRC-32 (MPEG-2) checking.
// ----------------------------------------------------------------------------
// The block takes one received byte per request on i_rx and hunts for frames
// of the form: start byte 0xFA, a register code that must match the
// configured value, a little-endian 16-bit payload length of at most
// MAX_PAYLOAD, the payload, and a little-endian CRC-32 (polynomial 04C11DB7,
// MSB first, initial value all ones, no final XOR) over header and payload.
// A wrong register code or an oversized length sends the parser back to
// hunting without a result. After the last CRC byte one result request is
// presented on o_res carrying the status (0 good, 1 CRC mismatch), the length
// and the measurement fields; payload bytes beyond the frame length read as
// zero. A byte is accepted every clock cycle while the queue has room: the
// parser classifies it in the cycle it is accepted and writes it into a
// two-entry queue, and the checker takes one entry per cycle with a byte-wide
// CRC update, which sets the one-byte-per-cycle throughput, but holds a last
// byte while an older result waits on o_res. A frame's last byte passes the
// queue and the checker's output register before its result is presented.
// A result waiting on o_res does not stop later bytes until the queue fills.
// The register code is written through i_cfg, which is always ready, and
// resets to 0xE0.
// ----------------------------------------------------------------------------
module crc32_frame_receiver_top
    import cfr_pkg::*;
(
    input  wire            i_clk,
    input  wire            i_rst_n,
    cfr_byte_if.sink       i_rx,
    cfr_cfg_if.sink        i_cfg,
    cfr_result_if.source   o_res
);

    // Classified bytes from the parser into the queue.
    logic f_cmd_valid;
    t_cmd f_cmd;
    logic q_ready;

    // Queue head towards the checker.
    logic q_valid;
    t_cmd q_cmd;
    logic b_pop;

    // The parser decides the frame layout and hands each byte on with its role.
    cfr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx        (i_rx),
        .i_cfg       (i_cfg),
        .i_q_ready   (q_ready),
        .o_cmd_valid (f_cmd_valid),
        .o_cmd       (f_cmd)
    );

    // The queue lets the parser keep taking bytes while a result is stalled.
    cfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_cmd_valid),
        .i_cmd   (f_cmd),
        .o_ready (q_ready),
        .i_pop   (b_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // The checker runs the CRC and builds the result in its output register.
    cfr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (b_pop),
        .o_res       (o_res)
    );

endmodule
`default_nettype wire
